// ----- rtl/core/bhs_pkg.sv -----
// Shared types and constants for the bucketed hash set core.
// No dependencies; imported by bucketed_hash_set_core and the port checker.
`default_nettype none

package bhs_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned KEY_W     = 20;
  localparam int unsigned S_TDATA_W = 24;  // cmd + key, padded to bytes
  localparam int unsigned M_TDATA_W = 8;   // result, padded to a byte

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // was_present lands in bit 0
  typedef struct packed {
    logic full_drop;
    logic was_present;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bucketed_hash_set_core.sv -----
// Bucketed hash set: each input transaction carries a command (add, remove,
// query; the unused code acts as a query) and a key, and returns one result
// telling whether the key was present before and whether an add was dropped
// because its bucket was full. A bucket is key mod NUM_BUCKETS and holds WAYS
// entries stored as one memory row, so each item is one row read and one
// conditional row write-back. Items are handled one at a time; when NUM_BUCKETS
// is not a power of two, each item also passes through the reciprocal modulo
// pipeline before its row is read. The next item is taken while a result waits
// in the output register. After reset the block clears the memory, one row per
// cycle, with s_axis_tready_o low.
// Depends on bhs_pkg, bhs_bucket_mod and bhs_bucket_ram.
`default_nettype none

module bucketed_hash_set_core #(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned WAYS        = 4,
  parameter int unsigned KEY_BITS    = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [1:0] cmd, [21:2] key, [23:22] zero
  input  logic [bhs_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] was_present, [1] full_drop, [7:2] zero
  output logic [bhs_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  import bhs_pkg::*;

  localparam int unsigned KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned EW  = KW + 1;       // {valid, key}
  localparam int unsigned RW  = WAYS * EW;
  localparam int unsigned WIW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HASH  = 4'b0100,
    ST_LOOK  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [BW-1:0] clr_cnt_q, clr_cnt_d;
  logic          out_valid_q, out_valid_d;
  result_t       out_res_q, out_res_d;
  cmd_e          cmd_q;
  logic [KW-1:0] key_q;
  logic [BW-1:0] bucket_q;

  logic          in_fire;
  cmd_e          in_cmd;
  logic [KW-1:0] in_key;
  logic          mod_done;
  logic [BW-1:0] mod_bucket;

  logic [RW-1:0] rd_row;
  logic [RW-1:0] new_row;
  logic          row_wr;
  logic          look_go;
  logic          clearing;
  logic          ram_wr_en;
  logic [BW-1:0] ram_wr_addr;
  logic [RW-1:0] ram_wr_data;

  logic [WAYS-1:0] hit, free;
  logic [WIW-1:0]  hit_idx, free_idx;
  logic            present, any_free;
  result_t         res;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign in_cmd          = cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
  assign in_key          = s_axis_tdata_i[CMD_W +: KW];

  bhs_bucket_mod #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KW          (KW),
    .BW          (BW)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .key_i    (in_key),
    .done_o   (mod_done),
    .bucket_o (mod_bucket)
  );

  bhs_bucket_ram #(
    .DEPTH (NUM_BUCKETS),
    .AW    (BW),
    .DW    (RW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (mod_done),
    .rd_addr_i (mod_bucket),
    .rd_data_o (rd_row)
  );

  // way match and first free way; lowest way wins
  always_comb begin
    hit      = '0;
    free     = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w]  = rd_row[w*EW + KW] && (rd_row[w*EW +: KW] == key_q);
      free[w] = !rd_row[w*EW + KW];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_idx = WIW'(w);
      end
      if (free[w]) begin
        free_idx = WIW'(w);
      end
    end
  end

  assign present  = |hit;
  assign any_free = |free;

  always_comb begin
    new_row         = rd_row;
    row_wr          = 1'b0;
    res.was_present = present;
    res.full_drop   = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        if (!present) begin
          if (any_free) begin
            new_row[free_idx*EW +: EW] = {1'b1, key_q};
            row_wr = 1'b1;
          end else begin
            res.full_drop = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        if (present) begin
          new_row[hit_idx*EW +: EW] = '0;
          row_wr = 1'b1;
        end
      end
      default: begin
        // query and the unused code only look
      end
    endcase
  end

  assign look_go     = (state_q == ST_LOOK) && (!out_valid_q || m_axis_tready_i);
  assign clearing    = (state_q == ST_CLEAR);
  assign ram_wr_en   = clearing || (look_go && row_wr);
  assign ram_wr_addr = clearing ? clr_cnt_q : bucket_q;
  assign ram_wr_data = clearing ? '0 : new_row;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = mod_done ? ST_LOOK : ST_HASH;
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (look_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_d = look_go || (out_valid_q && !m_axis_tready_i);
  assign out_res_d   = look_go ? res : out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    if (in_fire) begin
      cmd_q <= in_cmd;
      key_q <= in_key;
    end
    if (mod_done) begin
      bucket_q <= mod_bucket;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - $bits(result_t))'(0), out_res_q};

endmodule

`default_nettype wire

// ----- rtl/core/bhs_bucket_ram.sv -----
// Bucket row storage: one synchronous write port, one registered read port.
// Depends on nothing; instantiated by bucketed_hash_set_core.
`default_nettype none

module bhs_bucket_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 84
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/bhs_bucket_mod.sv -----
// Bucket index unit: key modulo the bucket count.
// Power-of-two counts are a combinational mask; others use a three-stage
// reciprocal multiply with one correcting subtract. No package dependency.
`default_nettype none

module bhs_bucket_mod #(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned KW          = 20,
  parameter int unsigned BW          = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [KW-1:0] key_i,
  output logic          done_o,
  output logic [BW-1:0] bucket_o
);

  localparam bit IsPow2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

  if (IsPow2) begin : g_mask
    logic [KW+BW-1:0] key_ext;

    assign key_ext  = {{BW{1'b0}}, key_i};
    assign bucket_o = key_ext[BW-1:0] & BW'(NUM_BUCKETS - 1);
    assign done_o   = start_i;
  end else begin : g_recip
    // q_est = (key * floor(2^S / N)) >> S is q or q-1, so r < 2N
    localparam int unsigned     S     = KW + BW;
    localparam int unsigned     MW    = KW + 1;
    localparam longint unsigned Recip = (64'd1 << S) / NUM_BUCKETS;

    logic [MW-1:0]    recip;
    logic [KW+MW-1:0] prod_q;
    logic [KW-1:0]    key1_q;
    logic [KW-1:0]    key2_q;
    logic [KW-1:0]    quot;
    logic [KW+BW-1:0] qn_q;
    logic [KW+BW-1:0] diff;
    logic [KW+BW-1:0] num_b;
    logic [BW-1:0]    rem_q;
    logic             v1_q, v2_q, v3_q;

    assign recip = Recip[MW-1:0];
    assign num_b = (KW+BW)'(NUM_BUCKETS);
    assign quot  = KW'(prod_q >> S);
    assign diff  = {{BW{1'b0}}, key2_q} - qn_q;

    always_ff @(posedge clk_i) begin
      prod_q <= (KW+MW)'(key_i) * (KW+MW)'(recip);
      key1_q <= key_i;
      qn_q   <= (KW+BW)'(quot) * num_b;
      key2_q <= key1_q;
      rem_q  <= (diff >= num_b) ? BW'(diff - num_b) : BW'(diff);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
        v3_q <= 1'b0;
      end else begin
        v1_q <= start_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end

    assign done_o   = v3_q;
    assign bucket_o = rem_q;
  end

endmodule

`default_nettype wire

// ----- rtl/core/bhs_checker.sv -----
// Port-level checks for bucketed_hash_set_core, bound to the top level.
// Depends on bhs_pkg.
`default_nettype none

module bhs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic [bhs_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [bhs_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import bhs_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a drop only happens on an absent key
  a_drop_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("full_drop with was_present");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[M_TDATA_W-1:2] == '0))
    else $error("result padding not zero");

  // one item in flight: no accept on the cycle right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("back-to-back accept");

endmodule

bind bucketed_hash_set_core bhs_checker u_bhs_checker (.*);

`default_nettype wire
